// ===== src/tsfc_pkg.sv =====
package tsfc_pkg;

  localparam int TEMP_W     = 12;
  localparam int DUTY_W     = 7;
  localparam int PWM_W      = 8;
  localparam int MS_W       = 22;
  localparam int CONV_W     = 10;
  localparam int CFG_DATA_W = 22;
  localparam int CFG_IDX_W  = 3;

  // Ramp numerator is a temperature span times a duty span.
  localparam int PROD_W    = TEMP_W + DUTY_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_FAN_OFF_TEMP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAN_ON_TEMP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAN_FULL_TEMP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THERMAL_IVL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_IVL     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CONVERSION     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_PRESENT = 3'd7;

  localparam logic signed [TEMP_W-1:0] FAN_OFF_RESET  = 12'sd448;
  localparam logic signed [TEMP_W-1:0] FAN_ON_RESET   = 12'sd480;
  localparam logic signed [TEMP_W-1:0] FAN_FULL_RESET = 12'sd640;
  localparam logic [DUTY_W-1:0]        MIN_DUTY_RESET = 7'd10;
  localparam logic [MS_W-1:0]          THERMAL_RESET  = 22'd60000;
  localparam logic [MS_W-1:0]          ACTIVE_RESET   = 22'd5000;
  localparam logic [CONV_W-1:0]        CONV_RESET     = 10'd750;

  localparam logic [DUTY_W-1:0] FULL_DUTY = 7'd100;

  // duty*255/100 is done as duty*(255*ceil(2^19/100)) >> 19, exact for duty <= 100.
  localparam int               PWM_SHIFT  = 19;
  localparam int               PWM_PROD_W = 28;
  localparam logic [20:0]      PWM_RECIP  = 21'd1336965;

  function automatic logic [PWM_W-1:0] pwm_from_duty(input logic [DUTY_W-1:0] duty);
    logic [PWM_PROD_W-1:0] prod;
    prod = PWM_PROD_W'(duty) * PWM_PROD_W'(PWM_RECIP);
    return prod[PWM_SHIFT +: PWM_W];
  endfunction

  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic commit;
  } tsfc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } tsfc_stat_t;

endpackage

// ===== src/tsfc_tick_if.sv =====
interface tsfc_tick_if;
  logic                              valid;
  logic                              ready;
  logic                              pwr_mon_active;
  logic                              rail3_powered;
  logic                              rail3_grant;
  logic                              measure_ok;
  logic                              read_ok;
  logic signed [tsfc_pkg::TEMP_W-1:0] sample_temp;
  logic                              shifter_grant;
  logic                              rail12_grant;

  modport source (
    output valid, pwr_mon_active, rail3_powered, rail3_grant, measure_ok,
           read_ok, sample_temp, shifter_grant, rail12_grant,
    input  ready
  );
  modport sink (
    input  valid, pwr_mon_active, rail3_powered, rail3_grant, measure_ok,
           read_ok, sample_temp, shifter_grant, rail12_grant,
    output ready
  );
endinterface

// ===== src/tsfc_status_if.sv =====
interface tsfc_status_if;
  logic                              valid;
  logic                              ready;
  logic                              fan_on;
  logic [tsfc_pkg::DUTY_W-1:0]        fan_percent;
  logic [tsfc_pkg::PWM_W-1:0]         pwm_code;
  logic                              thermal_event;
  logic                              temp_valid;
  logic signed [tsfc_pkg::TEMP_W-1:0] case_temp;
  logic                              converting;
  logic                              start_pulse;
  logic                              sample_taken;

  modport source (
    output valid, fan_on, fan_percent, pwm_code, thermal_event, temp_valid,
           case_temp, converting, start_pulse, sample_taken,
    input  ready
  );
  modport sink (
    input  valid, fan_on, fan_percent, pwm_code, thermal_event, temp_valid,
           case_temp, converting, start_pulse, sample_taken,
    output ready
  );
endinterface

// ===== src/thermal_sampler_fan_controller_unit.sv =====
// Channel   Direction  Word
// --------  ---------  -------------------------------------------------------
// tick      in         one millisecond tick: grants, sensor status, sample_temp
// status    out        one word per tick: fan, duty, PWM code, sampler flags
// cfg_*     in         register write: cfg_index selects, cfg_data is the value
//
// Each tick word goes from acceptance to the taking of the next tick through the
// ramp multiply, the divider load, nineteen divide steps and a check that the
// divider has finished, the commit, and the idle state that takes the next word.
// Reset is synchronous and active high; it restores the register defaults and clears
// all sampler and fan state. The status word sits in an output register, so a new tick
// is taken while it waits; the commit of the following tick holds until it has gone.
module thermal_sampler_fan_controller_unit (
  input  logic                            clk,
  input  logic                            rst,
  tsfc_tick_if.sink                       tick,
  tsfc_status_if.source                   status,
  input  logic                            cfg_we,
  input  logic [tsfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsfc_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Command and status between the sequencer and the datapath.
  tsfc_pkg::tsfc_cmd_t  cmd;
  tsfc_pkg::tsfc_stat_t stat;
  logic                 tick_ready;

  // The sequencer owns the tick handshake: it takes a word only when idle.
  tsfc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_ready (tick_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  assign tick.ready = tick_ready;

  // The datapath holds configuration, the sampler and fan state and the
  // status output register.
  tsfc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick),
    .status    (status),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== src/tsfc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tsfc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [tsfc_pkg::PROD_W-1:0]       num,
  input  logic [tsfc_pkg::TEMP_W-1:0]       den,
  output logic                              busy,
  output logic [tsfc_pkg::PROD_W-1:0]       quo
);

  logic [tsfc_pkg::TEMP_W-1:0]    rem;
  logic [tsfc_pkg::PROD_W-1:0]    shreg;
  logic [tsfc_pkg::DIV_CNT_W-1:0] count;
  logic [tsfc_pkg::TEMP_W:0]      trial;
  logic [tsfc_pkg::TEMP_W:0]      diff;
  logic                           fits;

  always_comb begin
    trial = {rem, shreg[tsfc_pkg::PROD_W-1]};
    diff  = trial - {1'b0, den};
    fits  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
      rem   <= '0;
      shreg <= num;
    end else if (busy) begin
      rem   <= fits ? diff[tsfc_pkg::TEMP_W-1:0] : trial[tsfc_pkg::TEMP_W-1:0];
      shreg <= {shreg[tsfc_pkg::PROD_W-2:0], fits};
      if (count == tsfc_pkg::DIV_CNT_W'(tsfc_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  assign quo = shreg;

endmodule

// ===== src/tsfc_ctrl.sv =====
// Sequencer: accept a tick, form the ramp product, divide, then commit.
module tsfc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick_valid,
  output logic                 tick_ready,
  input  tsfc_pkg::tsfc_stat_t stat,
  output tsfc_pkg::tsfc_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (tick_valid) state <= S_MUL;
        end
        S_MUL:   state <= S_START;
        S_START: state <= S_DIV;
        S_DIV: begin
          if (!stat.div_busy) state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    tick_ready    = (state == S_IDLE);
    cmd.load      = (state == S_IDLE) && tick_valid;
    cmd.mul       = (state == S_MUL);
    cmd.div_start = (state == S_START);
    cmd.commit    = (state == S_COMMIT) && stat.out_free;
  end

endmodule

// ===== src/tsfc_datapath.sv =====
// Configuration, sampler and fan state, ramp arithmetic and the result register.
module tsfc_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [tsfc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tsfc_pkg::CFG_DATA_W-1:0]        cfg_data,
  tsfc_tick_if.sink                              tick,
  tsfc_status_if.source                          status,
  input  tsfc_pkg::tsfc_cmd_t                    cmd,
  output tsfc_pkg::tsfc_stat_t                   stat
);

  localparam int TW = tsfc_pkg::TEMP_W;
  localparam int DW = tsfc_pkg::DUTY_W;
  localparam int MW = tsfc_pkg::MS_W;
  localparam int CW = tsfc_pkg::CONV_W;

  // Configuration registers.
  logic signed [TW-1:0] fan_off_temp, fan_on_temp, fan_full_temp;
  logic [DW-1:0]        min_duty_percent;
  logic [MW-1:0]        thermal_interval_ms, active_interval_ms;
  logic [CW-1:0]        conversion_ms;
  logic                 sensor_present;

  // Latched tick word.
  logic                 lat_mon, lat_r3pow, lat_r3grant, lat_meas_ok, lat_rd_ok;
  logic                 lat_sh, lat_r12;
  logic signed [TW-1:0] lat_temp;

  // Sampler and fan state.
  logic                 conv_state, fan_running, thermal_mode, valid_flag;
  logic [MW-1:0]        ms_since_sample;
  logic [CW-1:0]        ms_in_conversion;
  logic signed [TW-1:0] stored_temp;
  logic [DW-1:0]        duty_now;

  logic                 conv_state_next, fan_running_next, thermal_mode_next;
  logic                 valid_flag_next;
  logic [MW-1:0]        ms_since_sample_next;
  logic [CW-1:0]        ms_in_conversion_next;
  logic signed [TW-1:0] stored_temp_next;
  logic [DW-1:0]        duty_now_next;
  logic                 started, taken;

  // Ramp arithmetic.
  logic [DW-1:0]             duty_min, duty_span, ramp_duty;
  logic signed [TW:0]        temp_rise, temp_span;
  logic [tsfc_pkg::PROD_W-1:0] prod_q;
  logic [TW-1:0]             den_q;
  logic [tsfc_pkg::PROD_W-1:0] quo;
  logic                      div_busy;
  logic                      due, run;

  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      fan_off_temp        <= tsfc_pkg::FAN_OFF_RESET;
      fan_on_temp         <= tsfc_pkg::FAN_ON_RESET;
      fan_full_temp       <= tsfc_pkg::FAN_FULL_RESET;
      min_duty_percent    <= tsfc_pkg::MIN_DUTY_RESET;
      thermal_interval_ms <= tsfc_pkg::THERMAL_RESET;
      active_interval_ms  <= tsfc_pkg::ACTIVE_RESET;
      conversion_ms       <= tsfc_pkg::CONV_RESET;
      sensor_present      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tsfc_pkg::REG_FAN_OFF_TEMP:   fan_off_temp        <= cfg_data[TW-1:0];
        tsfc_pkg::REG_FAN_ON_TEMP:    fan_on_temp         <= cfg_data[TW-1:0];
        tsfc_pkg::REG_FAN_FULL_TEMP:  fan_full_temp       <= cfg_data[TW-1:0];
        tsfc_pkg::REG_MIN_DUTY:       min_duty_percent    <= cfg_data[DW-1:0];
        tsfc_pkg::REG_THERMAL_IVL:    thermal_interval_ms <= cfg_data[MW-1:0];
        tsfc_pkg::REG_ACTIVE_IVL:     active_interval_ms  <= cfg_data[MW-1:0];
        tsfc_pkg::REG_CONVERSION:     conversion_ms       <= cfg_data[CW-1:0];
        tsfc_pkg::REG_SENSOR_PRESENT: sensor_present      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat_mon     <= tick.pwr_mon_active;
      lat_r3pow   <= tick.rail3_powered;
      lat_r3grant <= tick.rail3_grant;
      lat_meas_ok <= tick.measure_ok;
      lat_rd_ok   <= tick.read_ok;
      lat_temp    <= tick.sample_temp;
      lat_sh      <= tick.shifter_grant;
      lat_r12     <= tick.rail12_grant;
    end
  end

  // Only the case fan_on_temp < t < fan_full_temp uses the quotient; then both
  // spans are positive and fit in TW unsigned bits.
  always_comb begin
    duty_min  = (min_duty_percent > tsfc_pkg::FULL_DUTY) ? tsfc_pkg::FULL_DUTY
                                                        : min_duty_percent;
    duty_span = tsfc_pkg::FULL_DUTY - duty_min;
    temp_rise = (TW+1)'(lat_temp) - (TW+1)'(fan_on_temp);
    temp_span = (TW+1)'(fan_full_temp) - (TW+1)'(fan_on_temp);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_q <= tsfc_pkg::PROD_W'(temp_rise[TW-1:0]) * tsfc_pkg::PROD_W'(duty_span);
      den_q  <= temp_span[TW-1:0];
    end
  end

  tsfc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (prod_q),
    .den   (den_q),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_comb begin
    if (lat_temp >= fan_full_temp) begin
      ramp_duty = tsfc_pkg::FULL_DUTY;
    end else if (lat_temp <= fan_on_temp) begin
      ramp_duty = duty_min;
    end else begin
      ramp_duty = duty_min + quo[DW-1:0];
    end
  end

  // One tick of the sampler and fan control.
  always_comb begin
    ms_since_sample_next  = (&ms_since_sample) ? ms_since_sample
                                               : ms_since_sample + 1'b1;
    ms_in_conversion_next = (&ms_in_conversion) ? ms_in_conversion
                                                : ms_in_conversion + 1'b1;
    conv_state_next   = conv_state;
    fan_running_next  = fan_running;
    thermal_mode_next = thermal_mode;
    valid_flag_next   = valid_flag;
    stored_temp_next  = stored_temp;
    duty_now_next     = duty_now;
    started           = 1'b0;
    taken             = 1'b0;

    if (thermal_mode) begin
      due = ms_since_sample_next >= thermal_interval_ms;
    end else if (lat_mon) begin
      due = ms_since_sample_next >= active_interval_ms;
    end else begin
      due = lat_r3pow;
    end
    run = fan_running ? (lat_temp >= fan_off_temp) : (lat_temp >= fan_on_temp);

    if (sensor_present) begin
      if (!conv_state) begin
        if (due) begin
          if (lat_r3grant && lat_meas_ok) begin
            conv_state_next       = 1'b1;
            ms_in_conversion_next = '0;
            started               = 1'b1;
          end else begin
            valid_flag_next = 1'b0;
          end
        end
      end else if (ms_in_conversion_next >= conversion_ms) begin
        if (lat_rd_ok) begin
          stored_temp_next     = lat_temp;
          valid_flag_next      = 1'b1;
          ms_since_sample_next = '0;
          taken                = 1'b1;
          if (run) begin
            if (fan_running) begin
              duty_now_next = ramp_duty;
            end else if (lat_sh && lat_r12) begin
              fan_running_next  = 1'b1;
              thermal_mode_next = 1'b1;
              duty_now_next     = ramp_duty;
            end
          end else if (fan_running) begin
            // Falling out of the run band while running means below the off threshold.
            duty_now_next     = '0;
            fan_running_next  = 1'b0;
            thermal_mode_next = 1'b0;
          end
        end else begin
          valid_flag_next = 1'b0;
        end
        conv_state_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_state       <= 1'b0;
      fan_running      <= 1'b0;
      thermal_mode     <= 1'b0;
      valid_flag       <= 1'b0;
      ms_since_sample  <= '0;
      ms_in_conversion <= '0;
      stored_temp      <= '0;
      duty_now         <= '0;
    end else if (cmd.commit) begin
      conv_state       <= conv_state_next;
      fan_running      <= fan_running_next;
      thermal_mode     <= thermal_mode_next;
      valid_flag       <= valid_flag_next;
      ms_since_sample  <= ms_since_sample_next;
      ms_in_conversion <= ms_in_conversion_next;
      stored_temp      <= stored_temp_next;
      duty_now         <= duty_now_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status.fan_on        <= fan_running_next;
      status.fan_percent   <= duty_now_next;
      status.pwm_code      <= tsfc_pkg::pwm_from_duty(duty_now_next);
      status.thermal_event <= thermal_mode_next;
      status.temp_valid    <= valid_flag_next;
      status.case_temp     <= stored_temp_next;
      status.converting    <= conv_state_next;
      status.start_pulse   <= started;
      status.sample_taken  <= taken;
    end
  end

  assign status.valid = out_valid;
  assign stat         = '{div_busy: div_busy, out_free: (!out_valid || status.ready)};

endmodule

// ===== tb/tsfc_status_checker.sv =====
module tsfc_status_checker (
  input  logic                            clk,
  input  logic                            rst,
  tsfc_tick_if                            tick,
  tsfc_status_if                          status,
  input  logic                            cfg_we,
  input  logic [tsfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsfc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fails,
  output int                              pending
);
  import tsfc_pkg::*;

  localparam int PWM_TOP = 255;

  typedef struct packed {
    logic                     fan_on;
    logic [DUTY_W-1:0]        fan_percent;
    logic [PWM_W-1:0]         pwm_code;
    logic                     thermal_event;
    logic                     temp_valid;
    logic signed [TEMP_W-1:0] case_temp;
    logic                     converting;
    logic                     start_pulse;
    logic                     sample_taken;
  } status_word_t;

  // Register copies.
  logic signed [TEMP_W-1:0] off_temp, on_temp, full_temp;
  logic [DUTY_W-1:0]        min_duty;
  logic [MS_W-1:0]          thermal_ivl, active_ivl;
  logic [CONV_W-1:0]        conv_wait;
  logic                     present;

  // Sampler and fan state.
  logic                     busy_conv;
  logic [MS_W-1:0]          since_sample;
  logic [CONV_W-1:0]        in_conv;
  logic                     fan_running;
  logic                     thermal_mode;
  logic                     temp_ok;
  logic signed [TEMP_W-1:0] last_temp;
  logic [DUTY_W-1:0]        duty;

  status_word_t status_fifo[$];
  int errors = 0;
  int word_no = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic field_check(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want)
      report($sformatf("word %0d %s is %0d, expected %0d", word_no, name, got, want));
  endtask

  function automatic logic [DUTY_W-1:0] ramp_percent(input logic signed [TEMP_W-1:0] t);
    int ti, lo, hi, mn;
    ti = int'(t);
    lo = int'(on_temp);
    hi = int'(full_temp);
    mn = (min_duty > FULL_DUTY) ? int'(FULL_DUTY) : int'(min_duty);
    if (ti >= hi) return FULL_DUTY;
    if (ti <= lo) return DUTY_W'(mn);
    return DUTY_W'(mn + ((ti - lo) * (int'(FULL_DUTY) - mn)) / (hi - lo));
  endfunction

  task automatic fan_control(input logic signed [TEMP_W-1:0] t, input logic sh,
                             input logic r12);
    logic run;
    logic [DUTY_W-1:0] d;
    run = fan_running ? (t >= off_temp) : (t >= on_temp);
    if (run) begin
      d = ramp_percent(t);
      if (fan_running) begin
        duty = d;
      end else if (sh && r12) begin
        fan_running = 1'b1;
        thermal_mode = 1'b1;
        duty = d;
      end
    end else if (fan_running) begin
      duty = '0;
      fan_running = 1'b0;
      if (t < off_temp) thermal_mode = 1'b0;
    end
  endtask

  task automatic advance_tick(output status_word_t r);
    logic due, started, taken;
    started = 1'b0;
    taken = 1'b0;
    if (since_sample != '1) since_sample++;
    if (in_conv != '1) in_conv++;
    if (present) begin
      if (!busy_conv) begin
        if (thermal_mode) due = since_sample >= thermal_ivl;
        else if (tick.pwr_mon_active) due = since_sample >= active_ivl;
        else due = tick.rail3_powered;
        if (due) begin
          if (tick.rail3_grant && tick.measure_ok) begin
            busy_conv = 1'b1;
            in_conv = '0;
            started = 1'b1;
          end else begin
            temp_ok = 1'b0;
          end
        end
      end else if (in_conv >= conv_wait) begin
        if (tick.read_ok) begin
          last_temp = tick.sample_temp;
          temp_ok = 1'b1;
          since_sample = '0;
          taken = 1'b1;
          fan_control(tick.sample_temp, tick.shifter_grant, tick.rail12_grant);
        end else begin
          temp_ok = 1'b0;
        end
        busy_conv = 1'b0;
      end
    end
    r.fan_on        = fan_running;
    r.fan_percent   = duty;
    r.pwm_code      = PWM_W'((int'(duty) * PWM_TOP) / int'(FULL_DUTY));
    r.thermal_event = thermal_mode;
    r.temp_valid    = temp_ok;
    r.case_temp     = last_temp;
    r.converting    = busy_conv;
    r.start_pulse   = started;
    r.sample_taken  = taken;
  endtask

  always @(posedge clk) begin
    status_word_t got, want, nxt;
    if (rst) begin
      off_temp     = FAN_OFF_RESET;
      on_temp      = FAN_ON_RESET;
      full_temp    = FAN_FULL_RESET;
      min_duty     = MIN_DUTY_RESET;
      thermal_ivl  = THERMAL_RESET;
      active_ivl   = ACTIVE_RESET;
      conv_wait    = CONV_RESET;
      present      = 1'b0;
      busy_conv    = 1'b0;
      since_sample = '0;
      in_conv      = '0;
      fan_running  = 1'b0;
      thermal_mode = 1'b0;
      temp_ok      = 1'b0;
      last_temp    = '0;
      duty         = '0;
      status_fifo.delete();
    end else begin
      // Retire first, so a word leaving at the same edge as a new tick
      // is matched against the older expectation.
      if (status.valid && status.ready) begin
        got.fan_on        = status.fan_on;
        got.fan_percent   = status.fan_percent;
        got.pwm_code      = status.pwm_code;
        got.thermal_event = status.thermal_event;
        got.temp_valid    = status.temp_valid;
        got.case_temp     = status.case_temp;
        got.converting    = status.converting;
        got.start_pulse   = status.start_pulse;
        got.sample_taken  = status.sample_taken;
        if (status_fifo.size() == 0) begin
          report($sformatf("word %0d arrived with no tick waiting", word_no));
        end else begin
          want = status_fifo.pop_front();
          field_check("fan_on", 32'(got.fan_on), 32'(want.fan_on));
          field_check("fan_percent", 32'(got.fan_percent), 32'(want.fan_percent));
          field_check("pwm_code", 32'(got.pwm_code), 32'(want.pwm_code));
          field_check("thermal_event", 32'(got.thermal_event), 32'(want.thermal_event));
          field_check("temp_valid", 32'(got.temp_valid), 32'(want.temp_valid));
          field_check("case_temp", 32'(got.case_temp), 32'(want.case_temp));
          field_check("converting", 32'(got.converting), 32'(want.converting));
          field_check("start_pulse", 32'(got.start_pulse), 32'(want.start_pulse));
          field_check("sample_taken", 32'(got.sample_taken), 32'(want.sample_taken));
        end
        word_no++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FAN_OFF_TEMP:   off_temp    = cfg_data[TEMP_W-1:0];
          REG_FAN_ON_TEMP:    on_temp     = cfg_data[TEMP_W-1:0];
          REG_FAN_FULL_TEMP:  full_temp   = cfg_data[TEMP_W-1:0];
          REG_MIN_DUTY:       min_duty    = cfg_data[DUTY_W-1:0];
          REG_THERMAL_IVL:    thermal_ivl = cfg_data[MS_W-1:0];
          REG_ACTIVE_IVL:     active_ivl  = cfg_data[MS_W-1:0];
          REG_CONVERSION:     conv_wait   = cfg_data[CONV_W-1:0];
          REG_SENSOR_PRESENT: present     = cfg_data[0];
          default: ;
        endcase
      end
      if (tick.valid && tick.ready) begin
        advance_tick(nxt);
        status_fifo.push_back(nxt);
      end
    end
    pending <= status_fifo.size();
    fails   <= errors;
  end

endmodule

// ===== tb/tb_thermal_sampler_fan_controller_unit.sv =====
module tb_thermal_sampler_fan_controller_unit;
  import tsfc_pkg::*;

  // The run is stopped here if the block hangs. A correct run ends before
  // it is reached, even with every stall at its longest.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles allowed after the last status word before a register write or the verdict.
  localparam int SETTLE = 40;

  // One tick word as the sender sees it.
  typedef struct packed {
    logic                     mon;
    logic                     r3pow;
    logic                     r3grant;
    logic                     meas_ok;
    logic                     rd_ok;
    logic signed [TEMP_W-1:0] temp;
    logic                     sh;
    logic                     r12;
  } tick_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tsfc_tick_if   tick_ch ();
  tsfc_status_if status_ch ();

  int fails;
  int pending;
  int cycles = 0;

  // Percent chance that an idle burst starts; both sides share it.
  int idle_pct = 0;
  int stall_left = 0;

  // Copies of the thresholds, so random temperatures can be aimed at them.
  logic signed [TEMP_W-1:0] off_t, on_t, full_t;

  thermal_sampler_fan_controller_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .status    (status_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tsfc_status_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .status    (status_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  always #4 clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The status receiver stalls in bursts. A burst starts
  // with the chance in idle_pct, so setting it to zero gives a clean stretch.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      status_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(1, 7) - 1;
      status_ch.ready <= 1'b0;
    end else begin
      status_ch.ready <= 1'b1;
    end
  end

  // Offer one tick word and hold it until the block takes it. The task
  // returns in the time step of the accepting edge, so the next call may
  // keep valid high without lowering it first.
  task automatic send_word(input tick_word_t w);
    if ($urandom_range(0, 99) < idle_pct) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    tick_ch.valid             <= 1'b1;
    tick_ch.pwr_mon_active    <= w.mon;
    tick_ch.rail3_powered     <= w.r3pow;
    tick_ch.rail3_grant       <= w.r3grant;
    tick_ch.measure_ok        <= w.meas_ok;
    tick_ch.read_ok           <= w.rd_ok;
    tick_ch.sample_temp       <= w.temp;
    tick_ch.shifter_grant     <= w.sh;
    tick_ch.rail12_grant      <= w.r12;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
  endtask

  // Directed words are written out field by field for readability.
  task automatic tick_with(input int mon, input int r3pow, input int r3grant,
                           input int meas_ok, input int rd_ok,
                           input logic signed [TEMP_W-1:0] temp,
                           input int sh, input int r12);
    tick_word_t w;
    w = '{mon[0], r3pow[0], r3grant[0], meas_ok[0], rd_ok[0], temp, sh[0], r12[0]};
    send_word(w);
  endtask

  // Lower valid and wait until every expected status word has come, then
  // let the block settle. pending is registered in the checker, hence the
  // leading edge.
  task automatic drain();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Rewrites every register; only called while the block is idle.
  task automatic set_config(input int off, input int on, input int full, input int mind,
                            input int thermal, input int active, input int conv,
                            input int present);
    off_t  = TEMP_W'(off);
    on_t   = TEMP_W'(on);
    full_t = TEMP_W'(full);
    write_reg(REG_FAN_OFF_TEMP, off);
    write_reg(REG_FAN_ON_TEMP, on);
    write_reg(REG_FAN_FULL_TEMP, full);
    write_reg(REG_MIN_DUTY, mind);
    write_reg(REG_THERMAL_IVL, thermal);
    write_reg(REG_ACTIVE_IVL, active);
    write_reg(REG_CONVERSION, conv);
    write_reg(REG_SENSOR_PRESENT, present);
  endtask

  function automatic logic signed [TEMP_W-1:0] near(input logic signed [TEMP_W-1:0] base);
    return TEMP_W'(int'(base) + int'($urandom_range(0, 6)) - 3);
  endfunction

  // Mostly well-formed ticks: grants usually given, temperatures aimed at
  // the thresholds and the ramp. The rest is raw noise on every field.
  function automatic tick_word_t random_word();
    tick_word_t w;
    if ($urandom_range(0, 99) < 85) begin
      w.mon     = ($urandom_range(0, 1) != 0);
      w.r3pow   = ($urandom_range(0, 3) != 0);
      w.r3grant = ($urandom_range(0, 9) != 0);
      w.meas_ok = ($urandom_range(0, 9) != 0);
      w.rd_ok   = ($urandom_range(0, 9) != 0);
      w.sh      = ($urandom_range(0, 9) != 0);
      w.r12     = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 4))
        0: w.temp = near(off_t);
        1: w.temp = near(on_t);
        2: w.temp = near(full_t);
        3: begin
          if (full_t > on_t)
            w.temp = TEMP_W'(int'(on_t) + int'($urandom_range(0, int'(full_t) - int'(on_t))));
          else
            w.temp = TEMP_W'($urandom);
        end
        default: w.temp = TEMP_W'($urandom);
      endcase
    end else begin
      w = tick_word_t'($urandom);
    end
    return w;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_word(random_word());
    drain();
  endtask

  initial begin
    // Every input is known before the first edge.
    tick_ch.valid             = 1'b0;
    tick_ch.pwr_mon_active    = 1'b0;
    tick_ch.rail3_powered     = 1'b0;
    tick_ch.rail3_grant       = 1'b0;
    tick_ch.measure_ok        = 1'b0;
    tick_ch.read_ok           = 1'b0;
    tick_ch.sample_temp       = '0;
    tick_ch.shifter_grant     = 1'b0;
    tick_ch.rail12_grant      = 1'b0;
    status_ch.ready           = 1'b0;
    cfg_we                    = 1'b0;
    cfg_index                 = '0;
    cfg_data                  = '0;
    off_t                     = FAN_OFF_RESET;
    on_t                      = FAN_ON_RESET;
    full_t                    = FAN_FULL_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 20;

    // After reset the sensor counts as absent: only the counters move, even
    // with every grant given and a sample due.
    tick_with(1, 1, 1, 1, 1, 12'sd2047, 1, 1);
    tick_with(0, 1, 1, 1, 1, -12'sd2048, 1, 1);
    tick_with(1, 0, 1, 1, 1, 12'sd0, 1, 1);
    drain();

    // Directed walk with a zero conversion time and one-tick intervals, so
    // a reading comes on the tick after each start.
    set_config(448, 480, 640, 10, 1, 1, 0, 1);
    tick_with(0, 0, 1, 1, 1, 12'sd0, 1, 1);     // nothing due without monitoring or rail
    tick_with(0, 1, 0, 1, 1, 12'sd0, 1, 1);     // due by rail, but the rail is refused
    tick_with(1, 1, 1, 0, 1, 12'sd0, 1, 1);     // due by interval, start refused
    tick_with(1, 0, 1, 1, 1, 12'sd0, 1, 1);     // conversion starts
    tick_with(1, 0, 1, 1, 0, 12'sd100, 1, 1);   // read fails
    tick_with(1, 0, 1, 1, 1, 12'sd0, 1, 1);
    tick_with(0, 0, 0, 0, 1, 12'sd2047, 0, 1);  // hot, but the level shifter is refused
    tick_with(1, 0, 1, 1, 1, 12'sd0, 1, 1);
    tick_with(0, 0, 0, 0, 1, 12'sd2047, 1, 0);  // hot, but the 12V rail is refused
    tick_with(1, 0, 1, 1, 1, 12'sd0, 1, 1);
    tick_with(0, 0, 0, 0, 1, 12'sd2047, 1, 1);  // fan on at full duty, thermal mode
    tick_with(0, 0, 1, 1, 1, 12'sd0, 1, 1);     // thermal interval makes it due
    tick_with(0, 0, 1, 1, 1, 12'sd560, 0, 0);   // interpolated duty
    tick_with(0, 0, 1, 1, 1, 12'sd0, 1, 1);
    tick_with(0, 0, 1, 1, 1, 12'sd480, 1, 1);   // ramp start gives the minimum
    tick_with(0, 0, 1, 1, 1, 12'sd0, 1, 1);
    tick_with(0, 0, 1, 1, 1, 12'sd448, 1, 1);   // at the off threshold the fan keeps running
    tick_with(0, 0, 1, 1, 1, 12'sd0, 1, 1);
    tick_with(0, 0, 1, 1, 1, 12'sd447, 1, 1);   // just below: fan and thermal mode drop
    tick_with(1, 0, 1, 1, 1, 12'sd0, 1, 1);
    tick_with(1, 0, 1, 1, 1, -12'sd2048, 1, 1); // coldest reading
    tick_with(1, 0, 1, 1, 1, 12'sd0, 1, 1);
    tick_with(1, 0, 1, 1, 1, 12'sd640, 1, 1);   // exactly at full
    tick_with(0, 0, 1, 1, 1, 12'sd0, 1, 1);
    tick_with(0, 0, 1, 1, 1, 12'sd639, 1, 1);   // just under full
    drain();

    // Default thresholds with short waits.
    idle_pct = 25;
    set_config(448, 480, 640, 10, 2, 1, $urandom_range(0, 3), 1);
    run_random(100);

    // Extreme registers: the widest thresholds with full below on, a
    // minimum above 100, a zero thermal interval and the largest active one.
    idle_pct = 40;
    set_config(-2048, 2047, -2048, 127, 0, 4194303, 1, 1);
    run_random(60);

    // Whole working range as the ramp, zero minimum and zero intervals,
    // with no idling at all.
    idle_pct = 0;
    set_config(-880, -880, 2000, 0, 0, 0, 2, 1);
    run_random(80);

    // Full at or below on never uses the quotient; minimum of exactly 100.
    idle_pct = 30;
    set_config(300, 700, 650, 100, 3, 2, 3, 1);
    run_random(60);

    // A long conversion wait; enough ticks for a conversion to finish.
    // The thermal interval never runs out here.
    idle_pct = 10;
    set_config(448, 480, 640, 55, 4194303, 1, 100, 1);
    run_random(150);

    // Sensor taken away again with odd register values.
    idle_pct = 30;
    set_config(-880, 2000, 100, 50, 1, 1, 0, 0);
    run_random(30);

    // Last stretch runs with both sides always ready.
    idle_pct = 0;
    set_config(448, 480, 640, 10, 1, 1, 0, 1);
    run_random(100);

    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
